>>> rtl/decimal_integer_line_parser_macros.svh
// Assertion macros used by the top level of the decimal integer line parser.
`ifndef DECIMAL_INTEGER_LINE_PARSER_MACROS_SVH
`define DECIMAL_INTEGER_LINE_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Checks that the consequent holds in the same cycle as the antecedent.
`define DILP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Checks that the consequent holds in the cycle after the antecedent.
`define DILP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define DILP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DILP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/dilp_pkg.sv
// Types and constants of the decimal integer line parser.
package dilp_pkg;

   // Width of the two's complement result before it is sign-extended.
   localparam int VALUE_WIDTH = 64;
   localparam int MAG_W       = VALUE_WIDTH - 1;
   localparam int OUT_W       = 64;
   localparam int MAX_W       = 63;
   localparam int WIDE_W      = MAX_W + 4;
   localparam int CSR_IDX_W   = 1;

   // Largest magnitude the result width can carry.
   localparam logic [MAX_W-1:0] VALUE_CAP =
      MAX_W'((65'd1 << (VALUE_WIDTH - 1)) - 65'd1);

   localparam logic [MAX_W-1:0] MAX_VALUE_RESET   = MAX_W'(64'd2147483647);
   localparam logic             SIGNED_MODE_RESET = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_MODE = 1'b1;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   typedef enum logic [4:0] {
      PH_START  = 5'b00001,
      PH_SIGN   = 5'b00010,
      PH_ZEROS  = 5'b00100,
      PH_DIGITS = 5'b01000,
      PH_DROP   = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [MAG_W-1:0] magnitude;
      logic             negative;
   } dilp_state_type;

   typedef struct packed {
      logic                    emit;
      logic signed [OUT_W-1:0] value;
      logic                    status;
   } dilp_result_type;

endpackage

>>> rtl/dilp_if.sv
// Valid/ready channel interfaces for the parser's character and result streams.
interface dilp_req_if import dilp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;

   modport source (output valid, output char_code, output end_of_input, input ready);
   modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface dilp_rsp_if import dilp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] value;
   logic                    status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

>>> rtl/decimal_integer_line_parser.sv
// Top level of the decimal integer line parser: beat registers, state and configuration.
//
// The parser takes one ASCII character per beat on the request channel and turns each
// line into a signed decimal integer, giving one response beat per finished line: the
// value with status 0, or status 1 with value 0 when the line is rejected (a stray
// character, a sign on its own, a minus while signed mode is off, or a magnitude above
// the smaller of max_value and the largest value the result width holds). After a
// rejection the rest of the line is dropped silently. A newline or an end-of-input beat
// closes a line; an empty line or a line of zeros gives 0. The block sustains one
// character per clock cycle while the response side does not stall; a beat is first
// held in the input register and the character is then resolved by a single times-ten
// add and limit compare into the parser state and the response register. Stalls on
// the response side hold the input register and, once that is full, lower
// req_bus.ready. The configuration registers are written through the csr_ port and
// should only be changed while no line is in progress.
`include "decimal_integer_line_parser_macros.svh"

module decimal_integer_line_parser import dilp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   dilp_req_if.sink             req_bus,
   dilp_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MAX_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [MAX_W-1:0] max_value_ff;
   logic             signed_mode_ff;

   // Input register holding one accepted character beat.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_eoi_ff;

   // Parser state carried between characters.
   dilp_state_type state_ff, state_in;

   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_value_ff;
   logic                    rsp_status_ff;

   dilp_result_type step_result;
   logic            advance;
   logic            req_take;

   // The character in the input register is resolved whenever the response register
   // can take whatever it produces.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready  = !in_valid_ff || advance;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.status = rsp_status_ff;

   dilp_step u_step (
      .state        (state_ff),
      .char_code    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .max_value    (max_value_ff),
      .signed_mode  (signed_mode_ff),
      .state_next   (state_in),
      .result       (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step_result.emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff   <= MAX_VALUE_RESET;
         signed_mode_ff <= SIGNED_MODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_VALUE:   max_value_ff   <= csr_wdata;
            CSR_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default:         max_value_ff   <= max_value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_START, magnitude: '0, negative: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_bus.char_code;
         in_eoi_ff  <= req_bus.end_of_input;
      end
      if (advance && step_result.emit) begin
         rsp_value_ff  <= step_result.value;
         rsp_status_ff <= step_result.status;
      end
   end

   // A rejection always carries a zero value.
   `DILP_ASSERT_IMPLIES(a_reject_zero, clock, reset, rsp_valid_ff && rsp_status_ff, rsp_value_ff == '0)
   // Only a line with significant digits holds a non-zero magnitude.
   `DILP_ASSERT_IMPLIES(a_mag_idle, clock, reset, state_ff.phase != PH_DIGITS, state_ff.magnitude == '0)
   // A held character is never lost while the response side stalls.
   `DILP_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_char_ff))

endmodule

>>> rtl/dilp_step.sv
// Next-state and result logic of the parser for one character.
module dilp_step import dilp_pkg::*; (
   input  dilp_state_type  state,
   input  logic [7:0]      char_code,
   input  logic            end_of_input,
   input  logic [MAX_W-1:0] max_value,
   input  logic            signed_mode,
   output dilp_state_type  state_next,
   output dilp_result_type result
);

   logic                          eol;
   logic                          is_digit;
   logic [3:0]                    digit;
   logic [MAX_W-1:0]              limit;
   logic [MAG_W-1:0]              mag_base;
   logic [WIDE_W-1:0]             mag_wide;
   logic [WIDE_W-1:0]             scaled;
   logic                          take_ok;
   logic                          neg_keep;
   logic [VALUE_WIDTH-1:0]        mag_ext;
   logic signed [VALUE_WIDTH-1:0] final_value;
   dilp_state_type                take_next;
   dilp_state_type                clear_state;
   dilp_result_type               take_result;
   dilp_result_type               ok_zero;
   dilp_result_type               no_result;

   assign eol      = end_of_input || (char_code == CH_NEWLINE);
   assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign digit    = 4'(char_code - CH_ZERO);
   assign limit    = (max_value < VALUE_CAP) ? max_value : VALUE_CAP;

   // Only a line that already holds digits carries a magnitude forward.
   assign mag_base = (state.phase == PH_DIGITS) ? state.magnitude : '0;
   assign mag_wide = WIDE_W'(mag_base);
   // Times ten as two shifts, in a width that cannot overflow.
   assign scaled   = (mag_wide << 3) + (mag_wide << 1) + WIDE_W'(digit);
   assign take_ok  = is_digit && (scaled <= WIDE_W'(limit));
   assign neg_keep = state.negative && ((state.phase == PH_SIGN) ||
                     (state.phase == PH_ZEROS) || (state.phase == PH_DIGITS));

   assign mag_ext     = VALUE_WIDTH'(state.magnitude);
   assign final_value = state.negative ? -mag_ext : mag_ext;

   always_comb begin
      clear_state = '{phase: PH_START, magnitude: '0, negative: 1'b0};
      no_result   = '{emit: 1'b0, value: '0, status: 1'b0};
      ok_zero     = '{emit: 1'b1, value: '0, status: 1'b0};

      take_next.phase     = take_ok ? PH_DIGITS : PH_DROP;
      take_next.magnitude = take_ok ? scaled[MAG_W-1:0] : '0;
      take_next.negative  = take_ok && neg_keep;
      take_result         = '{emit: !take_ok, value: '0, status: 1'b1};

      state_next = state;
      result     = no_result;

      case (state.phase)
         PH_SIGN: begin
            if (eol) begin
               // A sign with nothing after it is rejected; the next line starts afresh.
               state_next = clear_state;
               result     = '{emit: 1'b1, value: '0, status: 1'b1};
            end else if (char_code == CH_ZERO) begin
               state_next.phase = PH_ZEROS;
            end else begin
               state_next = take_next;
               result     = take_result;
            end
         end
         PH_ZEROS: begin
            if (eol) begin
               state_next = clear_state;
               result     = ok_zero;
            end else if (char_code != CH_ZERO) begin
               state_next = take_next;
               result     = take_result;
            end
         end
         PH_DIGITS: begin
            if (eol) begin
               state_next = clear_state;
               result     = '{emit: 1'b1, value: OUT_W'(final_value), status: 1'b0};
            end else begin
               state_next = take_next;
               result     = take_result;
            end
         end
         PH_DROP: begin
            if (eol) begin
               state_next = clear_state;
            end
         end
         default: begin
            state_next = clear_state;
            if (eol) begin
               result = ok_zero;
            end else if ((char_code == CH_MINUS) && signed_mode) begin
               state_next.phase    = PH_SIGN;
               state_next.negative = 1'b1;
            end else if (char_code == CH_ZERO) begin
               state_next.phase = PH_ZEROS;
            end else begin
               state_next = take_next;
               result     = take_result;
            end
         end
      endcase
   end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the decimal integer line parser.
`timescale 1ns / 100ps

module tb;
   import dilp_pkg::*;

   // Idle time after the owed responses, for the beats that end in no response at all.
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_ITEMS = 1150;
   localparam int PHASE_ITEMS  = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int MAX_PRINTED  = 50;

   // Where the parser stands within the current line.
   typedef enum logic [2:0] {
      LN_START,
      LN_SIGN,
      LN_ZEROS,
      LN_DIGITS,
      LN_DROP
   } line_phase_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic                    status;
   } line_result_type;

   // A row of the directed table either sends one character beat or writes
   // a register. A character row is checked against the predictor, against a
   // response typed into the table, or is known to give no response at all.
   typedef enum logic [1:0] {ROW_CHAR, ROW_SET_MAX, ROW_SET_SIGNED} row_kind_type;
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TYPED} row_check_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [7:0]       code;
      logic             eoi;
      logic [MAX_W-1:0] data;
      row_check_type    check;
      logic             status;
   } row_type;

   localparam logic [MAX_W-1:0] NO_DATA   = '0;
   localparam logic [MAX_W-1:0] ALL_ONES  = {MAX_W{1'b1}};
   localparam int               DIRECTED_LEN = 32;

   localparam row_type DIRECTED [DIRECTED_LEN] = '{
      // An empty line, then end of input at line start with its character ignored.
      '{ROW_CHAR, CH_NEWLINE, 1'b0, NO_DATA, CHECK_TYPED, 1'b0},
      '{ROW_CHAR, 8'hFF,      1'b1, NO_DATA, CHECK_TYPED, 1'b0},
      // Negative zero written with two zeros.
      '{ROW_CHAR, CH_MINUS,   1'b0, NO_DATA, CHECK_NONE,  1'b0},
      '{ROW_CHAR, CH_ZERO,    1'b0, NO_DATA, CHECK_NONE,  1'b0},
      '{ROW_CHAR, CH_ZERO,    1'b0, NO_DATA, CHECK_NONE,  1'b0},
      '{ROW_CHAR, 8'h00,      1'b1, NO_DATA, CHECK_TYPED, 1'b0},
      // A sign on its own, after which the next character opens a fresh line.
      '{ROW_CHAR, CH_MINUS,   1'b0, NO_DATA, CHECK_NONE,  1'b0},
      '{ROW_CHAR, CH_NEWLINE, 1'b0, NO_DATA, CHECK_TYPED, 1'b1},
      '{ROW_CHAR, "7",        1'b0, NO_DATA, CHECK_MODEL, 1'b0},
      '{ROW_CHAR, CH_NEWLINE, 1'b0, NO_DATA, CHECK_MODEL, 1'b0},
      // A stray letter rejects the line and the rest of it is dropped quietly.
      '{ROW_CHAR, "a",        1'b0, NO_DATA, CHECK_TYPED, 1'b1},
      '{ROW_CHAR, "5",        1'b0, NO_DATA, CHECK_NONE,  1'b0},
      '{ROW_CHAR, CH_NEWLINE, 1'b0, NO_DATA, CHECK_NONE,  1'b0},
      // With a limit of zero only zero gets through.
      '{ROW_SET_MAX, 8'h00,   1'b0, NO_DATA, CHECK_NONE,  1'b0},
      '{ROW_CHAR, CH_ZERO,    1'b0, NO_DATA, CHECK_NONE,  1'b0},
      '{ROW_CHAR, CH_NEWLINE, 1'b0, NO_DATA, CHECK_TYPED, 1'b0},
      '{ROW_CHAR, "1",        1'b0, NO_DATA, CHECK_TYPED, 1'b1},
      '{ROW_CHAR, 8'h00,      1'b1, NO_DATA, CHECK_NONE,  1'b0},
      // Widest limit and unsigned mode, where a minus is just a stray character.
      '{ROW_SET_MAX, 8'h00,   1'b0, ALL_ONES, CHECK_NONE, 1'b0},
      '{ROW_SET_SIGNED, 8'h00, 1'b0, NO_DATA, CHECK_NONE, 1'b0},
      '{ROW_CHAR, CH_MINUS,   1'b0, NO_DATA, CHECK_TYPED, 1'b1},
      '{ROW_CHAR, CH_NEWLINE, 1'b0, NO_DATA, CHECK_NONE,  1'b0},
      '{ROW_CHAR, "9",        1'b0, NO_DATA, CHECK_MODEL, 1'b0},
      '{ROW_CHAR, CH_NEWLINE, 1'b0, NO_DATA, CHECK_MODEL, 1'b0},
      // Back to the reset settings, then the limit is lowered in the middle of
      // a line: the next digit is judged against the new limit.
      '{ROW_SET_SIGNED, 8'h00, 1'b0, 63'd1, CHECK_NONE,  1'b0},
      '{ROW_SET_MAX, 8'h00,   1'b0, MAX_VALUE_RESET, CHECK_NONE, 1'b0},
      '{ROW_CHAR, CH_MINUS,   1'b0, NO_DATA, CHECK_MODEL, 1'b0},
      '{ROW_CHAR, "1",        1'b0, NO_DATA, CHECK_MODEL, 1'b0},
      '{ROW_CHAR, "2",        1'b0, NO_DATA, CHECK_MODEL, 1'b0},
      '{ROW_SET_MAX, 8'h00,   1'b0, 63'd5,   CHECK_NONE,  1'b0},
      '{ROW_CHAR, "3",        1'b0, NO_DATA, CHECK_TYPED, 1'b1},
      '{ROW_CHAR, CH_NEWLINE, 1'b0, NO_DATA, CHECK_NONE,  1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MAX_W-1:0]     csr_wdata;

   dilp_req_if req_bus ();
   dilp_rsp_if rsp_bus ();

   decimal_integer_line_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // The predictor's own copy of the registers and of the line state.
   logic [MAX_W-1:0] cfg_max    = MAX_VALUE_RESET;
   logic             cfg_signed = SIGNED_MODE_RESET;
   line_phase_type   ln_phase   = LN_START;
   logic [MAG_W-1:0] ln_mag     = '0;
   logic             ln_neg     = 1'b0;

   // Responses still owed by the block, oldest first.
   line_result_type pending_results[$];

   int mismatch_count = 0;
   int taken_items    = 0;
   int snd_idle_pct   = 0;
   int stall_pct      = 0;
   int hold_len       = 0;
   logic hold_on;

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED)
         $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // The limit is whichever is smaller: the register or what the result width holds.
   function automatic logic [63:0] line_limit();
      return (cfg_max < VALUE_CAP) ? {1'b0, cfg_max} : {1'b0, VALUE_CAP};
   endfunction

   function automatic void clear_line();
      ln_phase = LN_START;
      ln_mag   = '0;
      ln_neg   = 1'b0;
   endfunction

   // A character that ought to be a digit. The limit test is done on the
   // quotient so that the times-ten never overflows; every rejection gives
   // status 1 with value 0, and all but a line end go on to drop the line.
   function automatic bit take_digit(input logic [7:0] c, input bit eol,
                                     output line_result_type r);
      logic [63:0] lim;
      logic [63:0] d;
      r   = '{value: '0, status: 1'b1};
      lim = line_limit();
      d   = {56'd0, c - CH_ZERO};
      if (eol) begin
         clear_line();
         return 1'b1;
      end
      if (c < CH_ZERO || c > CH_NINE || d > lim || {1'b0, ln_mag} > (lim - d) / 64'd10) begin
         clear_line();
         ln_phase = LN_DROP;
         return 1'b1;
      end
      ln_mag   = MAG_W'({1'b0, ln_mag} * 64'd10 + d);
      ln_phase = LN_DIGITS;
      return 1'b0;
   endfunction

   // Advances the line state by one character beat; returns 1 when the beat
   // finishes a line not yet rejected or rejects it, with the response in r.
   function automatic bit predict_char(input logic [7:0] c, input bit eoi,
                                       output line_result_type r);
      bit eol;
      eol = eoi || c == CH_NEWLINE;
      r   = '{value: '0, status: 1'b0};
      case (ln_phase)
         LN_SIGN: begin
            if (!eol && c == CH_ZERO) begin
               ln_phase = LN_ZEROS;
               return 1'b0;
            end
            return take_digit(c, eol, r);
         end
         LN_ZEROS: begin
            if (eol) begin
               clear_line();
               return 1'b1;
            end
            if (c == CH_ZERO)
               return 1'b0;
            return take_digit(c, 1'b0, r);
         end
         LN_DIGITS: begin
            if (eol) begin
               r.value = ln_neg ? -{1'b0, ln_mag} : {1'b0, ln_mag};
               clear_line();
               return 1'b1;
            end
            return take_digit(c, 1'b0, r);
         end
         LN_DROP: begin
            if (eol)
               clear_line();
            return 1'b0;
         end
         default: begin
            clear_line();
            if (eol)
               return 1'b1;
            // Signed mode only matters here, at the first character of a line.
            if (c == CH_MINUS && cfg_signed) begin
               ln_neg   = 1'b1;
               ln_phase = LN_SIGN;
               return 1'b0;
            end
            if (c == CH_ZERO) begin
               ln_phase = LN_ZEROS;
               return 1'b0;
            end
            return take_digit(c, 1'b0, r);
         end
      endcase
   endfunction

   // Offers one character beat, idling first at the current rate, and books
   // the response it should cause once the block has taken it. Called and
   // left at a falling edge; valid is left high so that back-to-back beats
   // never lower and raise it within one time step.
   task automatic send_char(input logic [7:0] c, input bit eoi, input row_check_type check,
                            input line_result_type typed);
      line_result_type got;
      bit              emitted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.char_code    <= c;
      req_bus.end_of_input <= eoi;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      taken_items++;
      emitted = predict_char(c, eoi, got);
      case (check)
         CHECK_MODEL: if (emitted) pending_results.push_back(got);
         CHECK_TYPED: pending_results.push_back(typed);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Waits until every owed response has come back and the pipeline has had
   // time to settle the beats that owe none.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MAX_W-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_VALUE)
         cfg_max = data;
      else
         cfg_signed = data[0];
   endtask

   // The receiver stalls at the current rate, and all the time during a hold.
   always @(negedge clock) begin
      rsp_bus.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
   end

   // Long hold-off on the response side, counted here in clock cycles, so that
   // the block fills up and has to push back on the character stream.
   initial begin : receiver_hold
      hold_on = 1'b0;
      forever begin
         wait (hold_len > 0);
         @(posedge clock);
         hold_on = 1'b1;
         repeat (hold_len) @(posedge clock);
         hold_on  = 1'b0;
         hold_len = 0;
      end
   end

   // Every response beat is matched against the oldest owed response.
   always @(posedge clock) begin : response_check
      line_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response beat value %0d status %0d with none owed",
                                      rsp_bus.value, rsp_bus.status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.value !== want.value)
               report_mismatch($sformatf("value %0d, expected %0d", rsp_bus.value, want.value));
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_bus.status,
                                         want.status));
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [7:0]  line_chars[$];
      logic [7:0]  stray;
      logic [63:0] lim;
      logic [63:0] mag;
      logic [63:0] pow;
      string       digits;
      int          pick;
      int          start_items;
      row_type     row;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.char_code    = '0;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_we               = 1'b0;
      csr_index            = CSR_MAX_VALUE;
      csr_wdata            = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: edges of the character set, the special lines and both
      // registers, walked row by row with no idling.
      for (int i = 0; i < DIRECTED_LEN; i++) begin
         row = DIRECTED[i];
         case (row.kind)
            ROW_SET_MAX:    write_reg(CSR_MAX_VALUE, row.data);
            ROW_SET_SIGNED: write_reg(CSR_SIGNED_MODE, row.data);
            default: send_char(row.code, row.eoi, row.check,
                               '{value: '0, status: row.status});
         endcase
      end

      // Random part in phases. Each phase picks an idling pattern and fresh
      // register settings, the extremes among them, and then sends whole lines.
      taken_items = 0;
      for (int ph = 0; taken_items < RANDOM_ITEMS; ph++) begin
         case (ph % 5)
            1: begin snd_idle_pct = 82; stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  stall_pct = 82; end
            3: begin snd_idle_pct = 37; stall_pct = 37; end
            default: begin snd_idle_pct = 0; stall_pct = 0; end
         endcase
         case (ph % 7)
            0: mag = {1'b0, ALL_ONES};
            1: mag = 64'd0;
            2: mag = {1'b0, MAX_VALUE_RESET};
            3: mag = 64'($urandom_range(999));
            4: begin
               // One less than a power of ten, so that all-nines lines sit on the edge.
               pow = 64'd1;
               repeat ($urandom_range(1, 18)) pow = pow * 64'd10;
               mag = pow - 64'd1;
            end
            5: mag = {$urandom, $urandom};
            default: mag = 64'($urandom);
         endcase
         write_reg(CSR_MAX_VALUE, mag[MAX_W-1:0]);
         // Upper bits of the signed-mode write are noise that the block must ignore.
         write_reg(CSR_SIGNED_MODE, {62'({$urandom, $urandom}), 1'(ph % 3 != 1)});
         if (ph % 5 == 4)
            hold_len = HOLD_CYCLES;

         start_items = taken_items;
         while (taken_items - start_items < PHASE_ITEMS && taken_items < RANDOM_ITEMS) begin
            line_chars.delete();
            lim  = line_limit();
            pick = $urandom_range(99);
            if (pick < 65) begin
               // A number near zero, at the limit, just below or just past it, or anywhere.
               case ($urandom_range(5))
                  0: mag = 64'($urandom_range(999));
                  1: mag = lim;
                  2: mag = lim + 64'd1;
                  3: mag = (lim > 64'd9) ? lim - 64'($urandom_range(9)) : 64'd0;
                  4: mag = {$urandom, $urandom} >> $urandom_range(63);
                  default: mag = 64'($urandom_range(9));
               endcase
               if (cfg_signed ? $urandom_range(2) == 0 : $urandom_range(9) == 0)
                  line_chars.push_back(CH_MINUS);
               if ($urandom_range(3) == 0)
                  repeat ($urandom_range(1, 3)) line_chars.push_back(CH_ZERO);
               digits = $sformatf("%0d", mag);
               foreach (digits[k])
                  line_chars.push_back(digits[k]);
               // An extra digit now and then pushes a large value past any limit.
               if ($urandom_range(11) == 0)
                  line_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
               // Some of them are broken by one stray character somewhere.
               if (pick >= 55) begin
                  stray = 8'($urandom_range(255));
                  if (stray >= CH_ZERO && stray <= CH_NINE)
                     stray ^= 8'h40;
                  line_chars.insert($urandom_range(line_chars.size()), stray);
               end
            end else if (pick < 80) begin
               line_chars.push_back(CH_MINUS);
            end else if (pick >= 88) begin
               repeat ($urandom_range(1, 5)) line_chars.push_back(8'($urandom_range(255)));
            end
            // Lines from 80 to 87 stay empty.
            foreach (line_chars[k])
               send_char(line_chars[k], 1'b0, CHECK_MODEL, '0);
            if ($urandom_range(6) == 0)
               send_char(8'($urandom_range(255)), 1'b1, CHECK_MODEL, '0);
            else
               send_char(CH_NEWLINE, 1'b0, CHECK_MODEL, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/dilp_pkg.sv
rtl/dilp_if.sv
rtl/dilp_step.sv
rtl/decimal_integer_line_parser.sv
tb/sv/tb.sv
